// ----- sv/svsrl_pkg.sv -----
// Shared types and constants for the servo slew-rate limiter.
package svsrl_pkg;

   // Field widths
   localparam int WIDTH_W   = 12;
   localparam int DELAY_W   = 16;
   localparam int TIME_W    = 32;
   localparam int PCT_W     = 7;
   localparam int DUTY_W    = 14;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;

   // Reset values of the registers
   localparam logic [WIDTH_W-1:0] OPEN_RESET  = 12'd1020;
   localparam logic [WIDTH_W-1:0] CLOSE_RESET = 12'd1920;
   localparam logic [WIDTH_W-1:0] STEP_RESET  = 12'd45;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd15;

   // Percent clamp limit
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // Reciprocal of 100, scaled by 2^26 and rounded up (exact for products below 2^19)
   localparam logic [19:0] RECIP_100   = 20'd671089;
   localparam int          RECIP_100_SH = 26;

   // Reciprocal of 20000, scaled by 2^42 and rounded up (exact for values below 2^28)
   localparam logic [27:0] RECIP_PERIOD    = 28'd219902326;
   localparam int          RECIP_PERIOD_SH = 42;

   // Bit positions of the result flags in rsp_tdata
   localparam int RSP_WRITTEN_BIT = 26;
   localparam int RSP_DONE_BIT    = 27;

   // Request function codes
   localparam logic FUNC_SET    = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // Register indexes of the write port
   typedef enum logic [1:0] {
      CSR_OPEN_WIDTH  = 2'd0,
      CSR_CLOSE_WIDTH = 2'd1,
      CSR_STEP        = 2'd2,
      CSR_STEP_DELAY  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] open_width_us;
      logic [WIDTH_W-1:0] close_width_us;
      logic [WIDTH_W-1:0] step_us;
      logic [DELAY_W-1:0] step_delay_ms;
   } cfg_type;

   // Register load strobes of the five pipeline stages
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s4_load;
      logic s5_load;
      logic commit;
   } pipe_ctrl_type;

   // Fields that ride along the mapping stages
   typedef struct packed {
      logic              func;
      logic              arm_idle;
      logic [TIME_W-1:0] now_ms;
   } tag_type;

   // Item as it reaches the ramp stage
   typedef struct packed {
      tag_type            tag;
      logic [WIDTH_W-1:0] width_us;
   } map_item_type;

   typedef struct packed {
      logic               done_res;
      logic               duty_written;
      logic [WIDTH_W-1:0] width_us;
   } ramp_item_type;

   // Packed so that its lowest bits match the rsp_tdata layout
   typedef struct packed {
      logic               done_res;
      logic               duty_written;
      logic [DUTY_W-1:0]  duty;
      logic [WIDTH_W-1:0] width_us;
   } result_type;

endpackage

// ----- sv/servo_slew_rate_limiter_core.sv -----
// Servo slew-rate limiter top level: ports, register file and pipeline control.
//
// Requests enter on req_*: req_tuser is the function (0 = set percent,
// 1 = update), req_tdata carries percent, arm-idle flag and millisecond time.
// A set item stores a new pending width; an update adopts it when the arm is
// idle and moves the pulse width one step toward it when the step delay has
// passed. Each request yields exactly one result on rsp_* with the width,
// the duty value and the moved / arrived flags.
// The datapath is a five-register pipeline (input, product, quotient, ramp
// state, duty). A result shows on rsp_tvalid once its item reaches the duty
// register; one request per cycle is accepted while rsp_tready stays high. The
// ramp state is updated in the stage-3 to stage-4 step, so back-to-back
// requests see each other's effects in order.
// Each stage holds its item while the next is full and held, so a stalled
// rsp_tready backs the pipeline up one stage at a time; req_tready drops only
// once all five stages hold items. Registers are written on csr_we with no wait
// and should change only while the pipeline is empty.
// Synchronous reset empties the pipeline and restores the register and ramp
// defaults (open 1020, close 1920, step 45, delay 15, width 1020).
module servo_slew_rate_limiter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // percent[7:0], arm_idle[8], now_ms[40:9], zero fill
   input  logic        req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // width_us[11:0], duty[25:12], duty_written[26],
                                    // done_res[27], zero fill
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import svsrl_pkg::*;

   cfg_type       cfg_ff;
   pipe_ctrl_type ctrl;
   map_item_type  item;
   ramp_item_type ramp;
   result_type    result;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic adv1, adv2, adv3, adv4, adv5;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{open_width_us: OPEN_RESET, close_width_us: CLOSE_RESET,
                     step_us: STEP_RESET, step_delay_ms: DELAY_RESET};
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OPEN_WIDTH:  cfg_ff.open_width_us  <= csr_wdata[WIDTH_W-1:0];
            CSR_CLOSE_WIDTH: cfg_ff.close_width_us <= csr_wdata[WIDTH_W-1:0];
            CSR_STEP:        cfg_ff.step_us        <= csr_wdata[WIDTH_W-1:0];
            CSR_STEP_DELAY:  cfg_ff.step_delay_ms  <= csr_wdata[DELAY_W-1:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // A stage advances when it is empty or its item moves on
   assign adv5 = !v5_ff || rsp_tready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign v1_in = adv1 ? req_tvalid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;
   assign v5_in = adv5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign ctrl = '{s1_load: adv1, s2_load: adv2, s3_load: adv3, s4_load: adv4,
                   s5_load: adv5, commit: adv4 && v3_ff};

   svsrl_map u_map (
      .clock        (clock),
      .ctrl         (ctrl),
      .cfg          (cfg_ff),
      .req_func     (req_tuser),
      .req_percent  ($signed(req_tdata[7:0])),
      .req_arm_idle (req_tdata[8]),
      .req_now_ms   (req_tdata[40:9]),
      .item         (item)
   );

   svsrl_ramp u_ramp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .cfg   (cfg_ff),
      .item  (item),
      .ramp  (ramp)
   );

   svsrl_duty u_duty (
      .clock  (clock),
      .ctrl   (ctrl),
      .ramp   (ramp),
      .result (result)
   );

   assign req_tready = adv1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {4'd0, result};

endmodule

// ----- sv/svsrl_map.sv -----
// Percent-to-width mapping: clamp, scale by the span, divide by 100.
module svsrl_map (
   input  logic                       clock,
   input  svsrl_pkg::pipe_ctrl_type   ctrl,
   input  svsrl_pkg::cfg_type         cfg,
   input  logic                       req_func,
   input  logic signed [7:0]          req_percent,
   input  logic                       req_arm_idle,
   input  logic [31:0]                req_now_ms,
   output svsrl_pkg::map_item_type    item
);
   import svsrl_pkg::*;

   logic [PCT_W-1:0]        s1_pct_in;
   logic [PCT_W-1:0]        s1_pct_ff;
   tag_type                 s1_tag_ff;
   logic signed [12:0]      span;
   logic signed [20:0]      prod_full;
   logic signed [19:0]      s2_prod_ff;
   tag_type                 s2_tag_ff;
   logic [18:0]             mag;
   logic [38:0]             quot_full;
   logic [WIDTH_W-1:0]      s3_quot_ff;
   logic                    s3_neg_ff;
   tag_type                 s3_tag_ff;

   // Clamp the percent to 0..100 on entry
   always_comb begin
      if (req_percent < 8'sd0) begin
         s1_pct_in = '0;
      end else if (req_percent > 8'sd100) begin
         s1_pct_in = PCT_MAX;
      end else begin
         s1_pct_in = req_percent[PCT_W-1:0];
      end
   end

   // Stage 1: input register
   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         s1_pct_ff <= s1_pct_in;
         s1_tag_ff <= '{func: req_func, arm_idle: req_arm_idle, now_ms: req_now_ms};
      end
   end

   // Stage 2: signed product of percent and span
   assign span      = $signed({1'b0, cfg.close_width_us}) - $signed({1'b0, cfg.open_width_us});
   assign prod_full = $signed({1'b0, s1_pct_ff}) * span;

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         s2_prod_ff <= prod_full[19:0];
         s2_tag_ff  <= s1_tag_ff;
      end
   end

   // Stage 3: divide the magnitude by 100 through the reciprocal, keep the sign
   assign mag       = s2_prod_ff[19] ? 19'(-s2_prod_ff) : s2_prod_ff[18:0];
   assign quot_full = mag * RECIP_100;

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         s3_quot_ff <= quot_full[RECIP_100_SH+WIDTH_W-1:RECIP_100_SH];
         s3_neg_ff  <= s2_prod_ff[19];
         s3_tag_ff  <= s2_tag_ff;
      end
   end

   // Offset from the open width; truncation toward zero falls out of sign-magnitude
   assign item.tag      = s3_tag_ff;
   assign item.width_us = s3_neg_ff ? (cfg.open_width_us - s3_quot_ff)
                                    : (cfg.open_width_us + s3_quot_ff);

endmodule

// ----- sv/svsrl_ramp.sv -----
// Ramp state: pending and adopted target, current width, move timing.
module svsrl_ramp (
   input  logic                       clock,
   input  logic                       reset,
   input  svsrl_pkg::pipe_ctrl_type   ctrl,
   input  svsrl_pkg::cfg_type         cfg,
   input  svsrl_pkg::map_item_type    item,
   output svsrl_pkg::ramp_item_type   ramp
);
   import svsrl_pkg::*;

   logic [WIDTH_W-1:0] current_ff, current_in;
   logic [WIDTH_W-1:0] target_ff, target_in;
   logic [WIDTH_W-1:0] pending_ff, pending_in;
   logic               waiting_ff, waiting_in;
   logic               arrival_ff, arrival_in;
   logic [TIME_W-1:0]  last_move_ff, last_move_in;
   ramp_item_type      s4_ff, s4_in;

   logic [TIME_W-1:0]  elapsed;
   logic               due;
   logic               up;
   logic [WIDTH_W-1:0] gap;

   assign elapsed = item.tag.now_ms - last_move_ff;
   assign due     = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.step_delay_ms};

   // Work out the next state and the result flags for the item in stage 3
   always_comb begin
      current_in   = current_ff;
      target_in    = target_ff;
      pending_in   = pending_ff;
      waiting_in   = waiting_ff;
      arrival_in   = arrival_ff;
      last_move_in = last_move_ff;
      up           = 1'b0;
      gap          = '0;
      s4_in        = '{done_res: 1'b0, duty_written: 1'b0, width_us: current_ff};
      if (item.tag.func == FUNC_SET) begin
         pending_in = item.width_us;
         waiting_in = 1'b1;
      end else begin
         // Adopt the pending target once the arm is idle
         if (waiting_ff && item.tag.arm_idle) begin
            target_in  = pending_ff;
            waiting_in = 1'b0;
            arrival_in = 1'b1;
         end
         if (current_ff != target_in) begin
            // Step toward the target, or snap when within one step
            up  = target_in > current_ff;
            gap = up ? (target_in - current_ff) : (current_ff - target_in);
            if (due) begin
               if (gap > cfg.step_us) begin
                  current_in = up ? (current_ff + cfg.step_us) : (current_ff - cfg.step_us);
               end else begin
                  current_in = target_in;
               end
               last_move_in       = item.tag.now_ms;
               s4_in.duty_written = 1'b1;
            end
         end else if (arrival_in) begin
            arrival_in     = 1'b0;
            s4_in.done_res = 1'b1;
         end
         s4_in.width_us = current_in;
      end
   end

   // Commit state as the item leaves stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff   <= OPEN_RESET;
         target_ff    <= OPEN_RESET;
         pending_ff   <= OPEN_RESET;
         waiting_ff   <= 1'b0;
         arrival_ff   <= 1'b0;
         last_move_ff <= '0;
      end else if (ctrl.commit) begin
         current_ff   <= current_in;
         target_ff    <= target_in;
         pending_ff   <= pending_in;
         waiting_ff   <= waiting_in;
         arrival_ff   <= arrival_in;
         last_move_ff <= last_move_in;
      end
   end

   // Stage 4 register
   always_ff @(posedge clock) begin
      if (ctrl.s4_load) begin
         s4_ff <= s4_in;
      end
   end

   assign ramp = s4_ff;

endmodule

// ----- sv/svsrl_duty.sv -----
// Duty conversion and result register: width * 65535 / 20000.
module svsrl_duty (
   input  logic                       clock,
   input  svsrl_pkg::pipe_ctrl_type   ctrl,
   input  svsrl_pkg::ramp_item_type   ramp,
   output svsrl_pkg::result_type      result
);
   import svsrl_pkg::*;

   logic [27:0] scaled;
   logic [55:0] duty_full;
   result_type  s5_ff, s5_in;

   // Multiply by 65535 as a shift and subtract, then by the reciprocal of the period
   assign scaled    = {ramp.width_us, 16'd0} - {16'd0, ramp.width_us};
   assign duty_full = scaled * RECIP_PERIOD;

   assign s5_in = '{done_res:     ramp.done_res,
                    duty_written: ramp.duty_written,
                    duty:         duty_full[RECIP_PERIOD_SH+DUTY_W-1:RECIP_PERIOD_SH],
                    width_us:     ramp.width_us};

   // Stage 5: result register
   always_ff @(posedge clock) begin
      if (ctrl.s5_load) begin
         s5_ff <= s5_in;
      end
   end

   assign result = s5_ff;

endmodule

// ----- sv/svsrl_checker.sv -----
// Port-level checks for the servo slew-rate limiter, bound to the top level.
module svsrl_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import svsrl_pkg::*;

   // A stalled result stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A move and an arrival never come in the same result
   a_move_or_arrive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_WRITTEN_BIT] && rsp_tdata[RSP_DONE_BIT]))
      else $error("move and arrival reported together");

   // Reset empties the pipeline and opens the request side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind servo_slew_rate_limiter_core svsrl_port_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
